### rtl/dcd_pkg.sv
// shared constants, types and codes for the double clap detector
`default_nettype none

package dcd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int LEVEL_BITS    = 16;
  localparam int GAP_BITS      = 17;
  localparam int MAX_FRAME     = 4096;
  localparam int FRAME_BITS    = $clog2(MAX_FRAME) + 1;
  localparam int POS_BITS      = $clog2(MAX_FRAME);
  localparam int EVENT_BITS    = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 17;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_SETTLE = 3'b010,
    PH_SEEK   = 3'b100
  } phase_t;

  typedef enum logic [EVENT_BITS-1:0] {
    EV_NONE    = 2'd0,
    EV_FIRST   = 2'd1,
    EV_DOUBLE  = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLAP_LEVEL  = 3'd0,
    REG_QUIET_LEVEL = 3'd1,
    REG_FRAME_SIZE  = 3'd2,
    REG_MIN_GAP     = 3'd3,
    REG_MAX_GAP     = 3'd4
  } reg_idx_t;

  localparam logic [LEVEL_BITS-1:0] CLAP_LEVEL_RST  = 16'd8847;
  localparam logic [LEVEL_BITS-1:0] QUIET_LEVEL_RST = 16'd3932;
  localparam logic [FRAME_BITS-1:0] FRAME_SIZE_RST  = 13'd2048;
  localparam logic [GAP_BITS-1:0]   MIN_GAP_RST     = 17'd4410;
  localparam logic [GAP_BITS-1:0]   MAX_GAP_RST     = 17'd35280;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] clap_level;
    logic [LEVEL_BITS-1:0] quiet_level;
    logic [FRAME_BITS-1:0] frame_size;
    logic [GAP_BITS-1:0]   min_gap;
    logic [GAP_BITS-1:0]   max_gap;
  } cfg_t;

  typedef struct packed {
    logic                  last;
    logic [LEVEL_BITS-1:0] peak;
  } frame_t;

  typedef struct packed {
    event_t              ev;
    logic [GAP_BITS-1:0] gap;
  } judge_t;

  typedef struct packed {
    phase_t              phase;
    logic [GAP_BITS-1:0] gap;
  } stat_t;

endpackage

`default_nettype wire

### rtl/dcd_ifs.sv
// valid/ready channel interfaces for samples and detector results
`default_nettype none

interface dcd_in_if import dcd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface dcd_out_if import dcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [EVENT_BITS-1:0] event_res;
  logic [LEVEL_BITS-1:0] frame_peak;
  logic [GAP_BITS-1:0]   gap;

  modport source (output valid, output event_res, output frame_peak, output gap,
                  input ready);
  modport sink (input valid, input event_res, input frame_peak, input gap,
                output ready);
endinterface

`default_nettype wire

### rtl/double_clap_detector.sv
// double clap detector top level: sample register, frame and phase logic, result register
//
// in_ch carries one signed 16-bit sample per item; out_ch carries one result
// item (event_res, frame_peak, gap) for every finished frame and nothing for
// other samples. both are valid/ready channels, taken when valid and ready are high.
// cfg_we/cfg_index/cfg_wdata write the five level, frame and gap registers;
// write them only while no sample is in flight.
// a sample is registered at its accepting edge and judged when the pipeline
// advances, which loads the result register: the sample that ends the frame
// passes the sample register and then the result register before it is shown.
// one sample per cycle is sustained while results are taken; the sample register
// and the result register form a two-stage pipeline that advances when the result
// register is empty or being taken.
// when the receiver stalls with a result waiting, one more sample is held in
// the sample register and in_ch.ready drops until the result goes.
// synchronous reset clears the pipeline, the phase (to idle), the running peak,
// the frame position and the gap count, and loads the register defaults.
`default_nettype none

module double_clap_detector import dcd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  dcd_in_if.sink                        in_ch,
  dcd_out_if.source                     out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t                   cfg_r;
  logic                   in_vld_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   out_vld_r;
  event_t                 ev_r;
  logic [LEVEL_BITS-1:0]  peak_r;
  logic [GAP_BITS-1:0]    gap_r;
  logic                   adv;
  logic                   fire;
  frame_t                 frame;
  judge_t                 res;
  stat_t                  stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clap_level  <= CLAP_LEVEL_RST;
      cfg_r.quiet_level <= QUIET_LEVEL_RST;
      cfg_r.frame_size  <= FRAME_SIZE_RST;
      cfg_r.min_gap     <= MIN_GAP_RST;
      cfg_r.max_gap     <= MAX_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLAP_LEVEL:  cfg_r.clap_level  <= cfg_wdata[LEVEL_BITS-1:0];
        REG_QUIET_LEVEL: cfg_r.quiet_level <= cfg_wdata[LEVEL_BITS-1:0];
        REG_FRAME_SIZE:  cfg_r.frame_size  <= cfg_wdata[FRAME_BITS-1:0];
        REG_MIN_GAP:     cfg_r.min_gap     <= cfg_wdata[GAP_BITS-1:0];
        REG_MAX_GAP:     cfg_r.max_gap     <= cfg_wdata[GAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign adv          = !out_vld_r || out_ch.ready;
  assign fire         = in_vld_r && adv;
  assign in_ch.ready  = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r <= in_ch.sample;
    end
  end

  dcd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (fire),
    .sample     (sample_r),
    .frame_size (cfg_r.frame_size),
    .frame      (frame)
  );

  dcd_judge u_judge (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .frame (frame),
    .cfg   (cfg_r),
    .res   (res),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fire && frame.last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && frame.last) begin
      ev_r   <= res.ev;
      peak_r <= frame.peak;
      gap_r  <= res.gap;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.event_res  = ev_r;
  assign out_ch.frame_peak = peak_r;
  assign out_ch.gap        = gap_r;

`ifndef ASSERT_OFF
  // a first clap is judged from idle, where the gap is always zero
  a_first_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.event_res == EV_FIRST)) |-> (out_ch.gap == '0))
    else $error("first clap reported with a nonzero gap");

  // the gap counter only runs outside idle
  a_idle_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.phase == PH_IDLE) |-> (stat.gap == '0))
    else $error("gap counter nonzero in idle");

  // a magnitude never exceeds one full scale
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.frame_peak <= LEVEL_BITS'(1 << (SAMPLE_BITS - 1))))
    else $error("frame peak out of range");

  // a result only appears after a frame-ending sample was processed
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(fire && frame.last))
    else $error("result appeared without a finished frame");
`endif

endmodule

`default_nettype wire

### rtl/dcd_frame.sv
// frame tracker: sample magnitude, running peak and frame position
`default_nettype none

module dcd_frame import dcd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [FRAME_BITS-1:0]  frame_size,
  output frame_t                      frame
);

  logic [LEVEL_BITS-1:0] peak_r, peak_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [LEVEL_BITS-1:0] mag;
  logic [LEVEL_BITS-1:0] peak_upd;
  logic [FRAME_BITS-1:0] eff_frame;
  logic [FRAME_BITS-1:0] pos_inc;

  // most negative sample wraps to the top bit alone, which is its exact magnitude
  assign mag = sample[SAMPLE_BITS-1] ? LEVEL_BITS'(-sample) : LEVEL_BITS'(sample);

  always_comb begin
    if (frame_size == '0) begin
      eff_frame = FRAME_BITS'(1);
    end else if (frame_size > FRAME_BITS'(MAX_FRAME)) begin
      eff_frame = FRAME_BITS'(MAX_FRAME);
    end else begin
      eff_frame = frame_size;
    end
  end

  assign peak_upd = (mag > peak_r) ? mag : peak_r;
  assign pos_inc  = {1'b0, pos_r} + FRAME_BITS'(1);

  always_comb begin
    frame.last = (pos_inc >= eff_frame);
    frame.peak = peak_upd;
    peak_nxt   = peak_r;
    pos_nxt    = pos_r;
    if (step) begin
      if (frame.last) begin
        peak_nxt = '0;
        pos_nxt  = '0;
      end else begin
        peak_nxt = peak_upd;
        pos_nxt  = pos_inc[POS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      pos_r  <= '0;
    end else begin
      peak_r <= peak_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/dcd_judge.sv
// phase machine and gap counter, judged at each frame end
`default_nettype none

module dcd_judge import dcd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   step,
  input  wire frame_t frame,
  input  wire cfg_t   cfg,
  output judge_t      res,
  output stat_t       stat
);

  phase_t              phase_r, phase_nxt;
  logic [GAP_BITS-1:0] gap_r, gap_nxt;
  logic [GAP_BITS-1:0] gap_inc;
  logic                counting;
  logic                loud;

  assign counting = (phase_r == PH_SETTLE) || (phase_r == PH_SEEK);
  // saturating count, raised before the frame is judged
  assign gap_inc  = (counting && (gap_r != '1)) ? gap_r + GAP_BITS'(1) : gap_r;
  assign loud     = (frame.peak > cfg.clap_level);

  always_comb begin
    phase_nxt = phase_r;
    gap_nxt   = gap_r;
    res.ev    = EV_NONE;
    res.gap   = gap_inc;
    if (step) begin
      gap_nxt = gap_inc;
      if (frame.last) begin
        case (phase_r)
          PH_SETTLE: begin
            if ((frame.peak < cfg.quiet_level) || (gap_inc > cfg.min_gap)) begin
              phase_nxt = PH_SEEK;
            end
          end
          PH_SEEK: begin
            // timeout wins over a loud frame
            if (gap_inc > cfg.max_gap) begin
              res.ev    = EV_TIMEOUT;
              phase_nxt = PH_IDLE;
              gap_nxt   = '0;
            end else if (loud) begin
              res.ev    = EV_DOUBLE;
              phase_nxt = PH_IDLE;
              gap_nxt   = '0;
            end
          end
          default: begin
            gap_nxt   = '0;
            res.gap   = '0;
            phase_nxt = PH_IDLE;
            if (loud) begin
              res.ev    = EV_FIRST;
              phase_nxt = PH_SETTLE;
            end
          end
        endcase
      end
    end
  end

  assign stat.phase = phase_r;
  assign stat.gap   = gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      gap_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      gap_r   <= gap_nxt;
    end
  end

endmodule

`default_nettype wire
